// ----- design/segment_closest_point_params_macros.svh -----
// Assertion macros shared by the segment closest point design.
`ifndef SEGMENT_CLOSEST_POINT_PARAMS_MACROS_SVH
`define SEGMENT_CLOSEST_POINT_PARAMS_MACROS_SVH
`ifndef ASSERT_OFF
`define SCP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define SCP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define SCP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/scp_pkg.sv -----
// Shared constants and types for the segment closest point design.
package scp_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FIFO_DEPTH      = 8;
  localparam int FIFO_CW         = $clog2(FIFO_DEPTH + 1);
  localparam int FRONT_STAGES    = 4;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;
endpackage

// ----- design/scp_front.sv -----
// Front end: register coordinates, form differences and the five dot products.
module scp_front
  import scp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DOTW        = 2 * (COORD_WIDTH + 1) + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] p_start_x,
  input  logic signed [COORD_WIDTH-1:0] p_start_y,
  input  logic signed [COORD_WIDTH-1:0] p_start_z,
  input  logic signed [COORD_WIDTH-1:0] p_end_x,
  input  logic signed [COORD_WIDTH-1:0] p_end_y,
  input  logic signed [COORD_WIDTH-1:0] p_end_z,
  input  logic signed [COORD_WIDTH-1:0] q_start_x,
  input  logic signed [COORD_WIDTH-1:0] q_start_y,
  input  logic signed [COORD_WIDTH-1:0] q_start_z,
  input  logic signed [COORD_WIDTH-1:0] q_end_x,
  input  logic signed [COORD_WIDTH-1:0] q_end_y,
  input  logic signed [COORD_WIDTH-1:0] q_end_z,
  output logic [FRONT_STAGES-1:0]       stage_vld,
  output logic [5*DOTW-1:0]             push_data
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] p0 [3];
  logic signed [COORD_WIDTH-1:0] p1 [3];
  logic signed [COORD_WIDTH-1:0] q0 [3];
  logic signed [COORD_WIDTH-1:0] q1 [3];
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] w [3];
  logic signed [PW-1:0] uu [3];
  logic signed [PW-1:0] uv [3];
  logic signed [PW-1:0] vv [3];
  logic signed [PW-1:0] uw [3];
  logic signed [PW-1:0] vw [3];
  logic signed [DOTW-1:0] a, b, c, d, e;
  logic [FRONT_STAGES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0[0] <= p_start_x; p0[1] <= p_start_y; p0[2] <= p_start_z;
      p1[0] <= p_end_x;   p1[1] <= p_end_y;   p1[2] <= p_end_z;
      q0[0] <= q_start_x; q0[1] <= q_start_y; q0[2] <= q_start_z;
      q1[0] <= q_end_x;   q1[1] <= q_end_y;   q1[2] <= q_end_z;
    end
    for (int k = 0; k < 3; k++) begin
      u[k]  <= DW'(p1[k]) - DW'(p0[k]);
      v[k]  <= DW'(q1[k]) - DW'(q0[k]);
      w[k]  <= DW'(p0[k]) - DW'(q0[k]);
      uu[k] <= PW'(u[k]) * PW'(u[k]);
      uv[k] <= PW'(u[k]) * PW'(v[k]);
      vv[k] <= PW'(v[k]) * PW'(v[k]);
      uw[k] <= PW'(u[k]) * PW'(w[k]);
      vw[k] <= PW'(v[k]) * PW'(w[k]);
    end
    a <= DOTW'(uu[0]) + DOTW'(uu[1]) + DOTW'(uu[2]);
    b <= DOTW'(uv[0]) + DOTW'(uv[1]) + DOTW'(uv[2]);
    c <= DOTW'(vv[0]) + DOTW'(vv[1]) + DOTW'(vv[2]);
    d <= DOTW'(uw[0]) + DOTW'(uw[1]) + DOTW'(uw[2]);
    e <= DOTW'(vw[0]) + DOTW'(vw[1]) + DOTW'(vw[2]);
  end

  assign stage_vld = vld;
  assign push_data = {a, b, c, d, e};
endmodule

// ----- design/scp_fifo.sv -----
// Short queue between the front end and the solver.
module scp_fifo
  import scp_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             rd_vld,
  output logic [WIDTH-1:0] rd_data,
  output fifo_stat_t       stat
);
  localparam int AW = $clog2(FIFO_DEPTH);

  logic [WIDTH-1:0]   mem [FIFO_DEPTH];
  logic [AW-1:0]      wptr, rptr;
  logic [FIFO_CW-1:0] count;
  logic               pop;

  // drain whenever anything is queued; the solver never stalls
  assign pop = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
    if (pop) begin
      rd_data <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= pop;
      if (push) wptr <= wptr + AW'(1);
      if (pop)  rptr <= rptr + AW'(1);
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign stat.count = count;
endmodule

// ----- design/scp_wmul.sv -----
// Two-stage signed multiplier built from four half-width partial products.
module scp_wmul #(
  parameter int AW = 52
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] x,
  input  logic signed [AW-1:0] y,
  output logic signed [2*AW-1:0] p
);
  localparam int H  = AW / 2;
  localparam int HW = AW - H;
  localparam int OW = 2 * AW;

  logic signed [2*H+1:0]  ll;
  logic signed [H+HW:0]   lh, hl;
  logic signed [2*HW-1:0] hh;

  always_ff @(posedge clk) begin
    ll <= $signed({1'b0, x[H-1:0]}) * $signed({1'b0, y[H-1:0]});
    lh <= $signed({1'b0, x[H-1:0]}) * $signed(y[AW-1:H]);
    hl <= $signed(x[AW-1:H]) * $signed({1'b0, y[H-1:0]});
    hh <= $signed(x[AW-1:H]) * $signed(y[AW-1:H]);
    p  <= (OW'(hh) <<< (2 * H)) + ((OW'(lh) + OW'(hl)) <<< H) + OW'(ll);
  end
endmodule

// ----- design/scp_back.sv -----
// Solver: determinant, clamping to segment ends and the two restoring divisions.
module scp_back
  import scp_pkg::*;
#(
  parameter int DOTW      = 52,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [5*DOTW-1:0]    in_data,
  output logic                 done,
  output logic [FRAC_BITS:0]   param_s,
  output logic [FRAC_BITS:0]   param_t
);
  localparam int WW  = 2 * DOTW + 2;
  localparam int LAT = FRAC_BITS + 7;

  logic signed [DOTW-1:0] a0, b0, c0, d0, e0;
  logic signed [DOTW-1:0] a1, b1, c1, d1, e1, a2, b2, c2, d2, e2;
  logic signed [2*DOTW-1:0] ac, bb, be, cd, ae, bd;
  logic [LAT-1:0] vld;

  assign {a0, b0, c0, d0, e0} = in_data;

  scp_wmul #(.AW(DOTW)) u_ac (.clk(clk), .x(a0), .y(c0), .p(ac));
  scp_wmul #(.AW(DOTW)) u_bb (.clk(clk), .x(b0), .y(b0), .p(bb));
  scp_wmul #(.AW(DOTW)) u_be (.clk(clk), .x(b0), .y(e0), .p(be));
  scp_wmul #(.AW(DOTW)) u_cd (.clk(clk), .x(c0), .y(d0), .p(cd));
  scp_wmul #(.AW(DOTW)) u_ae (.clk(clk), .x(a0), .y(e0), .p(ae));
  scp_wmul #(.AW(DOTW)) u_bd (.clk(clk), .x(b0), .y(d0), .p(bd));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_vld};
    end
  end

  // stage 3: determinant and unclamped numerators
  logic signed [WW-1:0] a3, b3, c3, d3, e3, det3, sn3, tn3;

  always_ff @(posedge clk) begin
    {a1, b1, c1, d1, e1} <= {a0, b0, c0, d0, e0};
    {a2, b2, c2, d2, e2} <= {a1, b1, c1, d1, e1};
    det3 <= WW'(ac) - WW'(bb);
    sn3  <= WW'(be) - WW'(cd);
    tn3  <= WW'(ae) - WW'(bd);
    a3 <= WW'(a2); b3 <= WW'(b2); c3 <= WW'(c2); d3 <= WW'(d2); e3 <= WW'(e2);
  end

  // stage 4: parallel case and clamp of s
  logic signed [WW-1:0] sn4, sd4, tn4, td4, a4, b4, d4;
  logic signed [WW-1:0] sn4_next, sd4_next, tn4_next, td4_next;

  always_comb begin
    if (det3 <= 0) begin
      sn4_next = '0; sd4_next = WW'(1); tn4_next = e3; td4_next = c3;
    end else begin
      sn4_next = sn3; sd4_next = det3; tn4_next = tn3; td4_next = det3;
      if (sn3 < 0) begin
        sn4_next = '0; tn4_next = e3; td4_next = c3;
      end else if (sn3 > det3) begin
        sn4_next = det3; tn4_next = e3 + b3; td4_next = c3;
      end
    end
  end

  always_ff @(posedge clk) begin
    sn4 <= sn4_next; sd4 <= sd4_next; tn4 <= tn4_next; td4 <= td4_next;
    a4 <= a3; b4 <= b3; d4 <= d3;
  end

  // stage 5: clamp of t, recompute s on the clamped edge
  logic signed [WW-1:0] sn5, sd5, tn5, td5;
  logic signed [WW-1:0] sn5_next, sd5_next, tn5_next, nd, xs;

  always_comb begin
    nd = -d4;
    xs = nd + b4;
    sn5_next = sn4; sd5_next = sd4; tn5_next = tn4;
    if (tn4 < 0) begin
      tn5_next = '0;
      if (nd < 0) sn5_next = '0;
      else if (nd > a4) sn5_next = sd4;
      else begin
        sn5_next = nd; sd5_next = a4;
      end
    end else if (tn4 > td4) begin
      tn5_next = td4;
      if (xs < 0) sn5_next = '0;
      else if (xs > a4) sn5_next = sd4;
      else begin
        sn5_next = xs; sd5_next = a4;
      end
    end
  end

  always_ff @(posedge clk) begin
    sn5 <= sn5_next; sd5 <= sd5_next; tn5 <= tn5_next; td5 <= td4;
  end

  // stage 6 onward: one quotient bit per stage
  logic [WW-1:0]        rem_s [FRAC_BITS+1];
  logic [WW-1:0]        rem_t [FRAC_BITS+1];
  logic [WW-1:0]        den_s [FRAC_BITS+1];
  logic [WW-1:0]        den_t [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_s   [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_t   [FRAC_BITS+1];
  logic [1:0]           fl_s  [FRAC_BITS+1];
  logic [1:0]           fl_t  [FRAC_BITS+1];
  logic [WW:0]          sh_s  [FRAC_BITS];
  logic [WW:0]          sh_t  [FRAC_BITS];

  always_comb begin
    for (int i = 0; i < FRAC_BITS; i++) begin
      sh_s[i] = {rem_s[i], 1'b0};
      sh_t[i] = {rem_t[i], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    // flags: bit 1 forces zero, bit 0 forces one
    fl_s[0]  <= {(sn5 <= 0) || (sd5 <= 0), sn5 >= sd5};
    fl_t[0]  <= {(tn5 <= 0) || (td5 <= 0), tn5 >= td5};
    rem_s[0] <= sn5;
    rem_t[0] <= tn5;
    den_s[0] <= sd5;
    den_t[0] <= td5;
    q_s[0]   <= '0;
    q_t[0]   <= '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      fl_s[i+1]  <= fl_s[i];
      fl_t[i+1]  <= fl_t[i];
      den_s[i+1] <= den_s[i];
      den_t[i+1] <= den_t[i];
      if (sh_s[i] >= {1'b0, den_s[i]}) begin
        rem_s[i+1] <= WW'(sh_s[i] - {1'b0, den_s[i]});
        q_s[i+1]   <= {q_s[i][FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_s[i+1] <= WW'(sh_s[i]);
        q_s[i+1]   <= {q_s[i][FRAC_BITS-2:0], 1'b0};
      end
      if (sh_t[i] >= {1'b0, den_t[i]}) begin
        rem_t[i+1] <= WW'(sh_t[i] - {1'b0, den_t[i]});
        q_t[i+1]   <= {q_t[i][FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_t[i+1] <= WW'(sh_t[i]);
        q_t[i+1]   <= {q_t[i][FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (fl_s[FRAC_BITS][1])      param_s <= '0;
    else if (fl_s[FRAC_BITS][0]) param_s <= ONE;
    else                         param_s <= {1'b0, q_s[FRAC_BITS]};
    if (fl_t[FRAC_BITS][1])      param_t <= '0;
    else if (fl_t[FRAC_BITS][0]) param_t <= ONE;
    else                         param_t <= {1'b0, q_t[FRAC_BITS]};
  end

  assign done = vld[LAT-1];
endmodule

// ----- design/segment_closest_point_params.sv -----
// Closest-point parameters of two 3-D segments, one segment pair per cycle while busy is low.
// From start to done an item passes the front dot-product stages, the queue,
// the split wide multipliers and the divider (one quotient bit per stage).
// Throughput: one item a cycle while busy is low.
// busy rises only if the queue plus items in the front stages would overflow.
// Synchronous active-high rst clears all valid state; results cannot be stalled.
`include "segment_closest_point_params_macros.svh"
module segment_closest_point_params
  import scp_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] p_start_x,
  input  logic signed [COORD_WIDTH-1:0] p_start_y,
  input  logic signed [COORD_WIDTH-1:0] p_start_z,
  input  logic signed [COORD_WIDTH-1:0] p_end_x,
  input  logic signed [COORD_WIDTH-1:0] p_end_y,
  input  logic signed [COORD_WIDTH-1:0] p_end_z,
  input  logic signed [COORD_WIDTH-1:0] q_start_x,
  input  logic signed [COORD_WIDTH-1:0] q_start_y,
  input  logic signed [COORD_WIDTH-1:0] q_start_z,
  input  logic signed [COORD_WIDTH-1:0] q_end_x,
  input  logic signed [COORD_WIDTH-1:0] q_end_y,
  input  logic signed [COORD_WIDTH-1:0] q_end_z,
  output logic                          done,
  output logic [PARAM_FRAC_BITS:0]      param_s,
  output logic [PARAM_FRAC_BITS:0]      param_t
);
  localparam int DOTW = 2 * (COORD_WIDTH + 1) + 2;
  localparam logic [PARAM_FRAC_BITS:0] ONE = (PARAM_FRAC_BITS+1)'(1) << PARAM_FRAC_BITS;

  logic [FRONT_STAGES-1:0] stage_vld;
  logic [5*DOTW-1:0]       push_data, rd_data;
  logic                    push, rd_vld, accept;
  fifo_stat_t              stat;
  logic [FIFO_CW:0]        pending;

  // count everything queued plus everything in flight that will land in the queue
  assign pending = (FIFO_CW+1)'(stat.count) + (FIFO_CW+1)'($countones(stage_vld));
  assign busy    = pending >= (FIFO_CW+1)'(FIFO_DEPTH);
  assign accept  = start && !busy;
  assign push    = stage_vld[FRONT_STAGES-1];

  scp_front #(.COORD_WIDTH(COORD_WIDTH), .DOTW(DOTW)) u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .p_start_x(p_start_x), .p_start_y(p_start_y), .p_start_z(p_start_z),
    .p_end_x(p_end_x), .p_end_y(p_end_y), .p_end_z(p_end_z),
    .q_start_x(q_start_x), .q_start_y(q_start_y), .q_start_z(q_start_z),
    .q_end_x(q_end_x), .q_end_y(q_end_y), .q_end_z(q_end_z),
    .stage_vld(stage_vld), .push_data(push_data)
  );

  scp_fifo #(.WIDTH(5 * DOTW)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .rd_vld(rd_vld), .rd_data(rd_data), .stat(stat)
  );

  scp_back #(.DOTW(DOTW), .FRAC_BITS(PARAM_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_vld(rd_vld), .in_data(rd_data),
    .done(done), .param_s(param_s), .param_t(param_t)
  );

  `SCP_ASSERT_IMP(a_no_overflow, clk, rst, push, !stat.full)
  `SCP_ASSERT_NXT(a_no_empty_read, clk, rst, stat.empty, !rd_vld)
  `SCP_ASSERT_IMP(a_param_range, clk, rst, done, (param_s <= ONE) && (param_t <= ONE))
endmodule
